/* hdl/mft_pkg.sv */
// shared types and codes for the mac address frame counter
package mft_pkg;

  localparam int MAC_W    = 48;
  localparam int RD_IDX_W = 5;
  localparam int SLOT_W   = 5;
  localparam int CNT_W    = 32;
  localparam int USED_W   = 6;

  // operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_ADDED = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // control part of the lookup token that walks down a chain
  typedef struct packed {
    logic       valid;
    logic       done;
    logic [1:0] status;
  } tok_t;

  // one table's share of a result word
  typedef struct packed {
    logic [MAC_W-1:0]  addr;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic [1:0]        status;
    logic [USED_W-1:0] used;
  } res_t;

endpackage

/* hdl/mft_cell.sv */
// one table entry: stored address and count, plus one stage of the lookup token
module mft_cell #(
  parameter int COUNT_BITS = 32,
  parameter int IDX_W      = 5,
  parameter int FILL_W     = 6,
  parameter int CELL_IDX   = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op,
  input  logic [mft_pkg::MAC_W-1:0]     key,
  input  logic [mft_pkg::RD_IDX_W-1:0]  rd_idx,
  input  logic [FILL_W-1:0]             fill,
  input  mft_pkg::tok_t                 tok_in,
  input  logic [mft_pkg::MAC_W-1:0]     addr_in,
  input  logic [COUNT_BITS-1:0]         cnt_in,
  input  logic [IDX_W-1:0]              slot_in,
  output mft_pkg::tok_t                 tok_out,
  output logic [mft_pkg::MAC_W-1:0]     addr_out,
  output logic [COUNT_BITS-1:0]         cnt_out,
  output logic [IDX_W-1:0]              slot_out
);
  import mft_pkg::*;

  localparam logic READABLE = (CELL_IDX < (2 ** RD_IDX_W));

  logic [MAC_W-1:0]      entry_addr_r, entry_addr_nxt;
  logic [COUNT_BITS-1:0] entry_cnt_r, entry_cnt_nxt;
  logic [COUNT_BITS-1:0] cnt_inc;
  tok_t                  tok_r, tok_nxt;
  logic [MAC_W-1:0]      addr_r, addr_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic                  in_use, at_tail, rd_match;

  // entry position against the fill count
  assign in_use   = FILL_W'(CELL_IDX) < fill;
  assign at_tail  = FILL_W'(CELL_IDX) == fill;
  assign rd_match = READABLE && (rd_idx == RD_IDX_W'(CELL_IDX));

  // saturating increment
  assign cnt_inc = (entry_cnt_r == {COUNT_BITS{1'b1}}) ? entry_cnt_r
                                                       : entry_cnt_r + COUNT_BITS'(1);

  // resolve the token here or pass it on
  always_comb begin
    entry_addr_nxt = entry_addr_r;
    entry_cnt_nxt  = entry_cnt_r;
    tok_nxt        = tok_in;
    addr_nxt       = addr_in;
    cnt_nxt        = cnt_in;
    slot_nxt       = slot_in;
    if (tok_in.valid && !tok_in.done) begin
      if (op == OP_RECORD) begin
        if (in_use && (entry_addr_r == key)) begin
          entry_cnt_nxt  = cnt_inc;
          tok_nxt.done   = 1'b1;
          tok_nxt.status = ST_HIT;
          addr_nxt       = key;
          cnt_nxt        = cnt_inc;
          slot_nxt       = IDX_W'(CELL_IDX);
        end else if (at_tail) begin
          entry_addr_nxt = key;
          entry_cnt_nxt  = COUNT_BITS'(1);
          tok_nxt.done   = 1'b1;
          tok_nxt.status = ST_ADDED;
          addr_nxt       = key;
          cnt_nxt        = COUNT_BITS'(1);
          slot_nxt       = IDX_W'(CELL_IDX);
        end
      end else if (in_use && rd_match) begin
        tok_nxt.done   = 1'b1;
        tok_nxt.status = ST_HIT;
        addr_nxt       = entry_addr_r;
        cnt_nxt        = entry_cnt_r;
        slot_nxt       = IDX_W'(CELL_IDX);
      end
    end
  end

  // token control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // entry storage and token payload
  always_ff @(posedge clk) begin
    entry_addr_r <= entry_addr_nxt;
    entry_cnt_r  <= entry_cnt_nxt;
    addr_r       <= addr_nxt;
    cnt_r        <= cnt_nxt;
    slot_r       <= slot_nxt;
  end

  assign tok_out  = tok_r;
  assign addr_out = addr_r;
  assign cnt_out  = cnt_r;
  assign slot_out = slot_r;

endmodule

/* hdl/mft_chain.sv */
// one address table: a row of entry cells, the fill count and the end-of-row result
module mft_chain #(
  parameter int ENTRIES    = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          inject,
  input  logic                          op,
  input  logic [mft_pkg::MAC_W-1:0]     key,
  input  logic [mft_pkg::RD_IDX_W-1:0]  rd_idx,
  output logic                          res_valid,
  output mft_pkg::res_t                 res,
  output logic [$clog2(ENTRIES+1)-1:0]  fill
);
  import mft_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES+1);
  localparam int EXT_W  = 64;

  tok_t                  tok   [ENTRIES+1];
  logic [MAC_W-1:0]      addr  [ENTRIES+1];
  logic [COUNT_BITS-1:0] cnt   [ENTRIES+1];
  logic [IDX_W-1:0]      slot  [ENTRIES+1];
  logic [FILL_W-1:0]     fill_r, fill_after;
  logic [EXT_W-1:0]      cnt_ext, slot_ext, used_ext;
  tok_t                  last;

  // fresh token at the head of the row
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = inject;
    tok[0].status = ST_HIT;
  end
  assign addr[0] = '0;
  assign cnt[0]  = '0;
  assign slot[0] = '0;

  // row of entry cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mft_cell #(
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W),
      .FILL_W     (FILL_W),
      .CELL_IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .key      (key),
      .rd_idx   (rd_idx),
      .fill     (fill_r),
      .tok_in   (tok[i]),
      .addr_in  (addr[i]),
      .cnt_in   (cnt[i]),
      .slot_in  (slot[i]),
      .tok_out  (tok[i+1]),
      .addr_out (addr[i+1]),
      .cnt_out  (cnt[i+1]),
      .slot_out (slot[i+1])
    );
  end

  assign last       = tok[ENTRIES];
  assign res_valid  = last.valid;
  assign fill_after = (last.done && (last.status == ST_ADDED)) ? fill_r + FILL_W'(1)
                                                                : fill_r;

  // fill count follows appends as tokens leave the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (last.valid) begin
      fill_r <= fill_after;
    end
  end

  // widen before cutting to the result field widths
  assign cnt_ext  = EXT_W'(cnt[ENTRIES]);
  assign slot_ext = EXT_W'(slot[ENTRIES]);
  assign used_ext = EXT_W'(fill_after);

  // result word for a token that leaves the row
  always_comb begin
    res.used = used_ext[USED_W-1:0];
    if (last.done) begin
      res.addr   = addr[ENTRIES];
      res.slot   = slot_ext[SLOT_W-1:0];
      res.count  = cnt_ext[CNT_W-1:0];
      res.status = last.status;
    end else if (op == OP_READ) begin
      res.addr   = '0;
      res.slot   = SLOT_W'(rd_idx);
      res.count  = '0;
      res.status = ST_EMPTY;
    end else begin
      res.addr   = '0;
      res.slot   = '0;
      res.count  = '0;
      res.status = ST_FULL;
    end
  end

  assign fill = fill_r;

endmodule

/* hdl/mac_address_frame_counter.sv */
// top level: per-address frame counters for destination and source addresses
// the token is registered in every entry cell, and the result in the output register before out_valid
// one word at a time: a new start is not taken until the result strobe; the lookup token walks the
//   row of entry cells one cell per cycle, both tables side by side
// busy is high from the accepted start until the result strobe; the receiver cannot stall
// reset: synchronous active-low rst_n empties both tables (fill counts to zero)
module mac_address_frame_counter #(
  parameter int ENTRIES    = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [mft_pkg::MAC_W-1:0]      in_dest_mac,
  input  logic [mft_pkg::MAC_W-1:0]      in_source_mac,
  input  logic [mft_pkg::RD_IDX_W-1:0]   in_read_index,
  output logic                           out_valid,
  output logic [mft_pkg::MAC_W-1:0]      out_dest_addr,
  output logic [mft_pkg::SLOT_W-1:0]     out_dest_slot,
  output logic [mft_pkg::CNT_W-1:0]      out_dest_count,
  output logic [1:0]                     out_dest_status,
  output logic [mft_pkg::USED_W-1:0]     out_dest_used,
  output logic [mft_pkg::MAC_W-1:0]      out_source_addr,
  output logic [mft_pkg::SLOT_W-1:0]     out_source_slot,
  output logic [mft_pkg::CNT_W-1:0]      out_source_count,
  output logic [1:0]                     out_source_status,
  output logic [mft_pkg::USED_W-1:0]     out_source_used
);
  import mft_pkg::*;

  localparam int FILL_W = $clog2(ENTRIES+1);

  logic                busy_r, inject_r, out_valid_r;
  logic                op_r;
  logic [MAC_W-1:0]    dest_mac_r, source_mac_r;
  logic [RD_IDX_W-1:0] idx_r;
  logic                accept;
  logic                dest_done, source_done;
  res_t                dest_res, source_res, dest_out_r, source_out_r;
  logic [FILL_W-1:0]   dest_fill, source_fill;

  assign accept = start && !busy_r;

  // control: busy window, token injection and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      inject_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      inject_r    <= accept;
      out_valid_r <= dest_done;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (dest_done) begin
        busy_r <= 1'b0;
      end
    end
  end

  // input word held for the whole walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_op;
      dest_mac_r   <= in_dest_mac;
      source_mac_r <= in_source_mac;
      idx_r        <= in_read_index;
    end
  end

  // destination table
  mft_chain #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dest (
    .clk       (clk),
    .rst_n     (rst_n),
    .inject    (inject_r),
    .op        (op_r),
    .key       (dest_mac_r),
    .rd_idx    (idx_r),
    .res_valid (dest_done),
    .res       (dest_res),
    .fill      (dest_fill)
  );

  // source table
  mft_chain #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_source (
    .clk       (clk),
    .rst_n     (rst_n),
    .inject    (inject_r),
    .op        (op_r),
    .key       (source_mac_r),
    .rd_idx    (idx_r),
    .res_valid (source_done),
    .res       (source_res),
    .fill      (source_fill)
  );

  // output register
  always_ff @(posedge clk) begin
    if (dest_done) begin
      dest_out_r   <= dest_res;
      source_out_r <= source_res;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_dest_addr     = dest_out_r.addr;
  assign out_dest_slot     = dest_out_r.slot;
  assign out_dest_count    = dest_out_r.count;
  assign out_dest_status   = dest_out_r.status;
  assign out_dest_used     = dest_out_r.used;
  assign out_source_addr   = source_out_r.addr;
  assign out_source_slot   = source_out_r.slot;
  assign out_source_count  = source_out_r.count;
  assign out_source_status = source_out_r.status;
  assign out_source_used   = source_out_r.used;

  // both tables finish the walk together
  a_chains_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    dest_done == source_done)
    else $error("destination and source tokens out of step");

  // a result ends the busy window
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  // one result per item
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  // fill counts never pass the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(dest_fill) <= ENTRIES) && (32'(source_fill) <= ENTRIES))
    else $error("fill count beyond table size");

endmodule
